@@ src/wsdu_pkg.sv @@
// shared types and constants for the websocket deframe and unmask unit
// no dependencies

package wsdu_pkg;

  // default width of the stored payload length
  localparam int unsigned LengthWidthDefault = 64;

  // result kinds
  typedef enum logic [1:0] {
    KindHeader = 2'd0,
    KindData   = 2'd1,
    KindError  = 2'd2
  } kind_e;

  // parser phases, one-hot
  typedef enum logic [4:0] {
    PhHdr0 = 5'b00001,
    PhHdr1 = 5'b00010,
    PhExt  = 5'b00100,
    PhKey  = 5'b01000,
    PhData = 5'b10000
  } phase_e;

  localparam logic [7:0] OpcodeMask = 8'h0F;
  localparam logic [7:0] Len7Mask   = 8'h7F;
  localparam logic [6:0] Len7Ext16  = 7'd126;
  localparam logic [6:0] Len7MaxDir = 7'd125;
  localparam logic [3:0] KeyBytes   = 4'd4;
  localparam logic [3:0] Ext16Bytes = 4'd2;
  localparam logic [3:0] Ext64Bytes = 4'd8;

endpackage

@@ src/websocket_deframe_unmask_unit.sv @@
// websocket frame parser and payload unmasker, top level
// depends on wsdu_pkg

// Usage:
// - input channel: one received link byte per request (rx_byte_i), with
//   in_valid_i / in_ready_o
// - output channel: header, unmasked payload byte or error results, with
//   out_valid_o / out_ready_i; each field is a port of its own
// - a byte is parsed in the cycle it is taken; its result, if any, appears
//   in the output register in the next cycle
// - throughput is one byte per clock, set by the single parse stage and
//   the output register; in_ready_o drops only while a result is held and
//   out_ready_i is low
// - header bytes and the first three mask-key bytes give no result; the
//   last key byte gives a header result, each payload byte a data result
// - a clear mask bit gives an error result, after which all further bytes
//   are taken and dropped until reset
// - reset (rst_ni low, asynchronous) returns the parser to the first header
//   byte of a frame and empties the output register

module websocket_deframe_unmask_unit #(
  parameter int unsigned LENGTH_WIDTH = wsdu_pkg::LengthWidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic        fin_flag_o,
  output logic [3:0]  frame_opcode_o,
  output logic [63:0] payload_length_o,
  output logic [7:0]  data_byte_o,
  output logic        last_o
);

  wsdu_pkg::phase_e phase_q, phase_d;
  logic [3:0]              hdr_cnt_q, hdr_cnt_d;
  logic                    ext_long_q, ext_long_d;
  logic                    fin_q, fin_d;
  logic [3:0]              opcode_q, opcode_d;
  logic [LENGTH_WIDTH-1:0] length_q, length_d;
  logic [31:0]             key_q, key_d;
  logic [LENGTH_WIDTH-1:0] idx_q, idx_d;
  logic                    halted_q, halted_d;

  logic        out_valid_q;
  logic [1:0]  kind_q;
  logic        fin_out_q;
  logic [3:0]  opcode_out_q;
  logic [63:0] length_out_q;
  logic [7:0]  data_q;
  logic        last_q;

  logic        res_valid;
  logic [1:0]  res_kind;
  logic [63:0] res_length;
  logic [7:0]  res_data;
  logic        res_last;

  logic                    accept;
  logic [6:0]              len7;
  logic [3:0]              cnt_inc;
  logic [7:0]              key_byte;
  logic [LENGTH_WIDTH:0]   idx_inc;
  logic                    is_last;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign len7    = 7'(rx_byte_i & wsdu_pkg::Len7Mask);
  assign cnt_inc = hdr_cnt_q + 4'd1;
  assign idx_inc = {1'b0, idx_q} + {{LENGTH_WIDTH{1'b0}}, 1'b1};
  assign is_last = idx_inc >= {1'b0, length_q};

  always_comb begin
    case (idx_q[1:0])
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    ext_long_d = ext_long_q;
    fin_d      = fin_q;
    opcode_d   = opcode_q;
    length_d   = length_q;
    key_d      = key_q;
    idx_d      = idx_q;
    halted_d   = halted_q;
    res_valid  = 1'b0;
    res_kind   = wsdu_pkg::KindHeader;
    res_length = 64'(length_q);
    res_data   = 8'd0;
    res_last   = 1'b0;

    if (!halted_q) begin
      case (phase_q)
        wsdu_pkg::PhHdr0: begin
          fin_d    = rx_byte_i[7];
          opcode_d = 4'(rx_byte_i & wsdu_pkg::OpcodeMask);
          phase_d  = wsdu_pkg::PhHdr1;
        end
        wsdu_pkg::PhHdr1: begin
          if (!rx_byte_i[7]) begin
            halted_d   = 1'b1;
            phase_d    = wsdu_pkg::PhHdr0;
            res_valid  = 1'b1;
            res_kind   = wsdu_pkg::KindError;
            res_length = 64'(len7);
          end else begin
            hdr_cnt_d = 4'd0;
            key_d     = 32'd0;
            if (len7 > wsdu_pkg::Len7MaxDir) begin
              length_d   = '0;
              ext_long_d = (len7 != wsdu_pkg::Len7Ext16);
              phase_d    = wsdu_pkg::PhExt;
            end else begin
              length_d = LENGTH_WIDTH'(len7);
              phase_d  = wsdu_pkg::PhKey;
            end
          end
        end
        wsdu_pkg::PhExt: begin
          // big-endian, only the low bits are kept
          length_d  = {length_q[LENGTH_WIDTH-9:0], rx_byte_i};
          hdr_cnt_d = cnt_inc;
          if (cnt_inc >= (ext_long_q ? wsdu_pkg::Ext64Bytes : wsdu_pkg::Ext16Bytes)) begin
            hdr_cnt_d = 4'd0;
            phase_d   = wsdu_pkg::PhKey;
          end
        end
        wsdu_pkg::PhKey: begin
          key_d     = {key_q[23:0], rx_byte_i};
          hdr_cnt_d = cnt_inc;
          if (cnt_inc >= wsdu_pkg::KeyBytes) begin
            hdr_cnt_d = 4'd0;
            idx_d     = '0;
            res_valid = 1'b1;
            res_kind  = wsdu_pkg::KindHeader;
            if (length_q == '0) begin
              phase_d  = wsdu_pkg::PhHdr0;
              res_last = 1'b1;
            end else begin
              phase_d = wsdu_pkg::PhData;
            end
          end
        end
        wsdu_pkg::PhData: begin
          res_valid = 1'b1;
          res_kind  = wsdu_pkg::KindData;
          res_data  = rx_byte_i ^ key_byte;
          res_last  = is_last;
          idx_d     = idx_inc[LENGTH_WIDTH-1:0];
          if (is_last) begin
            phase_d = wsdu_pkg::PhHdr0;
            idx_d   = '0;
          end
        end
        default: begin
          phase_d = wsdu_pkg::PhHdr0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= wsdu_pkg::PhHdr0;
      hdr_cnt_q  <= 4'd0;
      ext_long_q <= 1'b0;
      fin_q      <= 1'b0;
      opcode_q   <= 4'd0;
      length_q   <= '0;
      key_q      <= 32'd0;
      idx_q      <= '0;
      halted_q   <= 1'b0;
    end else if (accept) begin
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      ext_long_q <= ext_long_d;
      fin_q      <= fin_d;
      opcode_q   <= opcode_d;
      length_q   <= length_d;
      key_q      <= key_d;
      idx_q      <= idx_d;
      halted_q   <= halted_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= accept && res_valid;
    end
  end

  // result payload, loaded whenever the output register is free
  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      kind_q       <= res_kind;
      fin_out_q    <= fin_d;
      opcode_out_q <= opcode_d;
      length_out_q <= res_length;
      data_q       <= res_data;
      last_q       <= res_last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign fin_flag_o       = fin_out_q;
  assign frame_opcode_o   = opcode_out_q;
  assign payload_length_o = length_out_q;
  assign data_byte_o      = data_q;
  assign last_o           = last_q;

endmodule

@@ tb/websocket_deframe_unmask_checker.sv @@
// checker for the websocket deframe and unmask unit: watches both channels,
// predicts each result from the accepted link bytes and compares field by field
// depends on wsdu_pkg
`timescale 1ns / 100ps

module websocket_deframe_unmask_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic        fin_flag_i,
  input  logic [3:0]  frame_opcode_i,
  input  logic [63:0] payload_length_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int unsigned LenWidth = wsdu_pkg::LengthWidthDefault;
  localparam logic [63:0] LenKeep =
    (LenWidth >= 64) ? '1 : ((64'd1 << LenWidth) - 64'd1);

  typedef struct packed {
    logic [1:0]  kind;
    logic        fin;
    logic [3:0]  opcode;
    logic [63:0] length;
    logic [7:0]  data;
    logic        last;
  } frame_result_t;

  frame_result_t expected_results[$];
  int fails = 0;

  // parser copy
  wsdu_pkg::phase_e parse_phase = wsdu_pkg::PhHdr0;
  logic [3:0]  hdr_cnt     = '0;
  logic [3:0]  ext_need    = '0;
  logic        fin_q       = 1'b0;
  logic [3:0]  opcode_q    = '0;
  logic [63:0] len_q       = '0;
  logic [31:0] mask_key_q  = '0;
  logic [63:0] byte_idx    = '0;
  logic        halted_q    = 1'b0;

  function automatic frame_result_t make_result(input wsdu_pkg::kind_e kind,
                                                input logic [63:0] length,
                                                input logic [7:0] data,
                                                input logic last);
    frame_result_t r;
    r.kind   = kind;
    r.fin    = fin_q;
    r.opcode = opcode_q;
    r.length = length;
    r.data   = data;
    r.last   = last;
    return r;
  endfunction

  // advance the parser by one link byte; returns 1 when a result is due
  function automatic bit parse_link_byte(input logic [7:0] b, output frame_result_t r);
    logic [6:0] len7;
    logic [7:0] key_byte;
    logic       is_last;
    len7 = 7'(b & wsdu_pkg::Len7Mask);
    r = '0;
    if (halted_q) return 1'b0;
    case (parse_phase)
      wsdu_pkg::PhHdr0: begin
        fin_q = b[7];
        opcode_q = 4'(b & wsdu_pkg::OpcodeMask);
        parse_phase = wsdu_pkg::PhHdr1;
        return 1'b0;
      end
      wsdu_pkg::PhHdr1: begin
        if (!b[7]) begin
          halted_q = 1'b1;
          parse_phase = wsdu_pkg::PhHdr0;
          r = make_result(wsdu_pkg::KindError, 64'(len7), 8'h00, 1'b0);
          return 1'b1;
        end
        hdr_cnt = '0;
        mask_key_q = '0;
        if (len7 > wsdu_pkg::Len7MaxDir) begin
          len_q = '0;
          ext_need = (len7 == wsdu_pkg::Len7Ext16) ? wsdu_pkg::Ext16Bytes :
                                                     wsdu_pkg::Ext64Bytes;
          parse_phase = wsdu_pkg::PhExt;
        end else begin
          len_q = 64'(len7);
          parse_phase = wsdu_pkg::PhKey;
        end
        return 1'b0;
      end
      wsdu_pkg::PhExt: begin
        len_q = {len_q[55:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= ext_need) begin
          len_q = len_q & LenKeep;
          hdr_cnt = '0;
          parse_phase = wsdu_pkg::PhKey;
        end
        return 1'b0;
      end
      wsdu_pkg::PhKey: begin
        mask_key_q = {mask_key_q[23:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt < wsdu_pkg::KeyBytes) return 1'b0;
        hdr_cnt = '0;
        byte_idx = '0;
        if (len_q == '0) begin
          parse_phase = wsdu_pkg::PhHdr0;
          r = make_result(wsdu_pkg::KindHeader, 64'd0, 8'h00, 1'b1);
        end else begin
          parse_phase = wsdu_pkg::PhData;
          r = make_result(wsdu_pkg::KindHeader, len_q, 8'h00, 1'b0);
        end
        return 1'b1;
      end
      wsdu_pkg::PhData: begin
        // first key byte sits in the top bits
        key_byte = 8'(mask_key_q >> (5'd24 - {byte_idx[1:0], 3'b000}));
        is_last = (byte_idx + 64'd1 >= len_q);
        r = make_result(wsdu_pkg::KindData, len_q, b ^ key_byte, is_last);
        byte_idx = byte_idx + 64'd1;
        if (is_last) begin
          parse_phase = wsdu_pkg::PhHdr0;
          byte_idx = '0;
        end
        return 1'b1;
      end
      default: begin
        parse_phase = wsdu_pkg::PhHdr0;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    frame_result_t want;
    frame_result_t predicted;
    if (!rst_ni) begin
      expected_results.delete();
      parse_phase = wsdu_pkg::PhHdr0;
      hdr_cnt     = '0;
      ext_need    = '0;
      fin_q       = 1'b0;
      opcode_q    = '0;
      len_q       = '0;
      mask_key_q  = '0;
      byte_idx    = '0;
      halted_q    = 1'b0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, expected none, actual kind %0d len %0h data %0h",
                   $time, kind_i, payload_length_i, data_byte_i);
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 64'(want.kind), 64'(kind_i));
          check_field("fin_flag", 64'(want.fin), 64'(fin_flag_i));
          check_field("frame_opcode", 64'(want.opcode), 64'(frame_opcode_i));
          check_field("payload_length", want.length, payload_length_i);
          check_field("data_byte", 64'(want.data), 64'(data_byte_i));
          check_field("last", 64'(want.last), 64'(last_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (parse_link_byte(rx_byte_i, predicted)) expected_results.push_back(predicted);
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_results.size();
  end

endmodule

@@ tb/websocket_deframe_unmask_unit_tb.sv @@
// testbench top for the websocket deframe and unmask unit: drives framed
// link bytes with random gaps and back-pressure, gives the verdict
// depends on wsdu_pkg, websocket_deframe_unmask_unit and websocket_deframe_unmask_checker
`timescale 1ns / 100ps

module websocket_deframe_unmask_unit_tb;

  localparam int EncDirect = 0;
  localparam int EncExt16  = 1;
  localparam int EncExt64  = 2;

  localparam int RandomBytes   = 1750;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic        fin_flag_o;
  logic [3:0]  frame_opcode_o;
  logic [63:0] payload_length_o;
  logic [7:0]  data_byte_o;
  logic        last_o;

  int fail_count;
  int pending;
  int bytes_sent = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  websocket_deframe_unmask_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .fin_flag_o      (fin_flag_o),
    .frame_opcode_o  (frame_opcode_o),
    .payload_length_o(payload_length_o),
    .data_byte_o     (data_byte_o),
    .last_o          (last_o)
  );

  websocket_deframe_unmask_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_i          (kind_o),
    .fin_flag_i      (fin_flag_o),
    .frame_opcode_i  (frame_opcode_o),
    .payload_length_i(payload_length_o),
    .data_byte_i     (data_byte_o),
    .last_i          (last_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 17);
  end

  // ends the run when neither channel moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] head, input int enc,
                            input logic [63:0] len, input logic [31:0] key);
    logic [7:0] len_byte;
    int ext_bytes;
    longint unsigned k;
    ext_bytes = (enc == EncExt16) ? 2 : (enc == EncExt64) ? 8 : 0;
    len_byte = (enc == EncDirect) ? {1'b1, len[6:0]} :
               (enc == EncExt16) ? 8'hFE : 8'hFF;
    push_byte(head);
    push_byte(len_byte);
    for (int i = ext_bytes - 1; i >= 0; i--) push_byte(len[8*i +: 8]);
    for (int i = 3; i >= 0; i--) push_byte(key[8*i +: 8]);
    for (k = 0; k < len; k++) push_byte(8'($urandom_range(255)));
  endtask

  // hold the sender off until every result so far has been taken
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int pick;
    int enc;
    logic [63:0] len;
    bit paused;
    paused = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty frame, all-zero header and key
    send_frame(8'h00, EncDirect, 64'd0, 32'h0000_0000);
    // one payload byte, all header bits set
    calm = 1'b1;
    send_frame(8'hFF, EncDirect, 64'd1, 32'hFFFF_FFFF);
    calm = 1'b0;
    // empty frame through a non-minimal 64-bit length
    send_frame(8'h8A, EncExt64, 64'd0, 32'hA5C3_0F81);

    while (bytes_sent < RandomBytes + 27) begin
      calm = (bytes_sent >= 700 && bytes_sent < 1100);
      if (!paused && bytes_sent >= 400) begin
        drain_results();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 35) begin
        enc = EncDirect;
        len = 64'($urandom_range(5));
      end else if (pick < 60) begin
        enc = EncDirect;
        len = 64'($urandom_range(125));
      end else if (pick < 80) begin
        enc = EncExt16;
        len = 64'($urandom_range(300));
      end else begin
        enc = EncExt64;
        len = 64'($urandom_range(300));
      end
      send_frame(8'($urandom_range(255)), enc, len, $urandom());
    end
    calm = 1'b0;

    // clear mask bit halts the parser; the bytes after it give nothing
    push_byte(8'($urandom_range(255)));
    push_byte({1'b0, 7'($urandom_range(127))});
    repeat (16) push_byte(8'($urandom_range(255)));

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/wsdu_pkg.sv
src/websocket_deframe_unmask_unit.sv
tb/websocket_deframe_unmask_checker.sv
tb/websocket_deframe_unmask_unit_tb.sv
